// ===== hdl/lsbe_pkg.sv =====
// lsbe_pkg: shared types, register indexes and constants of the led strip bit encoder
// used by lsbe_config, lsbe_encode and led_strip_bit_encoder_unit; no dependencies
package lsbe_pkg;

    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned NUM_SLOTS       = 8;
    localparam int unsigned FACTOR_W        = 17;
    localparam int unsigned PRODUCT_W       = BYTE_W + FACTOR_W;
    localparam int unsigned GAP_BYTES_DEFAULT = 6;
    localparam int unsigned BYTES_PER_PIXEL = 3;

    // register indexes of the config port
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAMMA_ENABLE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH_COMPARE = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LOW_COMPARE  = 2'd3;

    // register reset values
    localparam logic [BYTE_W-1:0] BRIGHTNESS_RESET   = 8'd255;
    localparam logic              GAMMA_ENABLE_RESET = 1'b0;
    localparam logic [BYTE_W-1:0] HIGH_COMPARE_RESET = 8'd49;
    localparam logic [BYTE_W-1:0] LOW_COMPARE_RESET  = 8'd24;

    // fixed gamma factors
    localparam logic [BYTE_W-1:0] GREEN_GAMMA = 8'hB0;
    localparam logic [BYTE_W-1:0] BLUE_GAMMA  = 8'hF0;

    // byte order within a pixel
    localparam logic [1:0] BYTE_RED   = 2'd0;
    localparam logic [1:0] BYTE_GREEN = 2'd1;
    localparam logic [1:0] BYTE_BLUE  = 2'd2;

    // scale factor after reset: (255+1) << 8
    localparam logic [FACTOR_W-1:0] FACTOR_RESET = 17'h10000;

    typedef logic [NUM_SLOTS-1:0][BYTE_W-1:0] slot_row_t;

    // settings handed from the config block to the encoder
    typedef struct packed {
        logic [FACTOR_W-1:0] red_factor;
        logic [FACTOR_W-1:0] green_factor;
        logic [FACTOR_W-1:0] blue_factor;
        logic [BYTE_W-1:0]   high_compare;
        logic [BYTE_W-1:0]   low_compare;
    } cfg_t;

endpackage

// ===== hdl/lsbe_config.sv =====
// lsbe_config: configuration registers and registered per-color scale factors
// depends on lsbe_pkg
module lsbe_config (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [lsbe_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lsbe_pkg::BYTE_W-1:0]        cfg_data,
    output lsbe_pkg::cfg_t                     cfg
);

    logic [lsbe_pkg::BYTE_W-1:0]   brightness_reg, brightness_next;
    logic                          gamma_reg, gamma_next;
    logic [lsbe_pkg::BYTE_W-1:0]   high_reg, high_next;
    logic [lsbe_pkg::BYTE_W-1:0]   low_reg, low_next;
    logic [lsbe_pkg::FACTOR_W-1:0] red_factor_reg, red_factor_next;
    logic [lsbe_pkg::FACTOR_W-1:0] green_factor_reg, green_factor_next;
    logic [lsbe_pkg::FACTOR_W-1:0] blue_factor_reg, blue_factor_next;
    logic [lsbe_pkg::BYTE_W:0]     scale;

    always_comb
    begin
        brightness_next = brightness_reg;
        gamma_next      = gamma_reg;
        high_next       = high_reg;
        low_next        = low_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                lsbe_pkg::REG_BRIGHTNESS:   brightness_next = cfg_data;
                lsbe_pkg::REG_GAMMA_ENABLE: gamma_next      = cfg_data[0];
                lsbe_pkg::REG_HIGH_COMPARE: high_next       = cfg_data;
                lsbe_pkg::REG_LOW_COMPARE:  low_next        = cfg_data;
                default: ;
            endcase
        end
    end

    // factors follow the written values at the same edge
    always_comb
    begin
        scale           = {1'b0, brightness_next} + 9'd1;
        red_factor_next = {scale, 8'd0};
        if (gamma_next)
        begin
            green_factor_next = lsbe_pkg::FACTOR_W'(scale)
                              * lsbe_pkg::FACTOR_W'(lsbe_pkg::GREEN_GAMMA);
            blue_factor_next  = lsbe_pkg::FACTOR_W'(scale)
                              * lsbe_pkg::FACTOR_W'(lsbe_pkg::BLUE_GAMMA);
        end
        else
        begin
            green_factor_next = {scale, 8'd0};
            blue_factor_next  = {scale, 8'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg   <= lsbe_pkg::BRIGHTNESS_RESET;
            gamma_reg        <= lsbe_pkg::GAMMA_ENABLE_RESET;
            high_reg         <= lsbe_pkg::HIGH_COMPARE_RESET;
            low_reg          <= lsbe_pkg::LOW_COMPARE_RESET;
            red_factor_reg   <= lsbe_pkg::FACTOR_RESET;
            green_factor_reg <= lsbe_pkg::FACTOR_RESET;
            blue_factor_reg  <= lsbe_pkg::FACTOR_RESET;
        end
        else
        begin
            brightness_reg   <= brightness_next;
            gamma_reg        <= gamma_next;
            high_reg         <= high_next;
            low_reg          <= low_next;
            red_factor_reg   <= red_factor_next;
            green_factor_reg <= green_factor_next;
            blue_factor_reg  <= blue_factor_next;
        end
    end

    assign cfg.red_factor   = red_factor_reg;
    assign cfg.green_factor = green_factor_reg;
    assign cfg.blue_factor  = blue_factor_reg;
    assign cfg.high_compare = high_reg;
    assign cfg.low_compare  = low_reg;

endmodule

// ===== hdl/lsbe_encode.sv =====
// lsbe_encode: scales one selected color byte and maps its bits to compare slots
// depends on lsbe_pkg
module lsbe_encode (
    input  lsbe_pkg::cfg_t                  cfg,
    input  logic [lsbe_pkg::BYTE_W-1:0]     red,
    input  logic [lsbe_pkg::BYTE_W-1:0]     green,
    input  logic [lsbe_pkg::BYTE_W-1:0]     blue,
    input  logic [1:0]                      byte_sel,
    input  logic                            gap,
    output lsbe_pkg::slot_row_t             slots
);

    logic [lsbe_pkg::BYTE_W-1:0]    color;
    logic [lsbe_pkg::FACTOR_W-1:0]  factor;
    logic [lsbe_pkg::PRODUCT_W-1:0] product;
    logic [lsbe_pkg::BYTE_W-1:0]    scaled;

    always_comb
    begin
        unique case (byte_sel)
            lsbe_pkg::BYTE_RED:
            begin
                color  = red;
                factor = cfg.red_factor;
            end
            lsbe_pkg::BYTE_GREEN:
            begin
                color  = green;
                factor = cfg.green_factor;
            end
            default:
            begin
                color  = blue;
                factor = cfg.blue_factor;
            end
        endcase
    end

    assign product = {{lsbe_pkg::FACTOR_W{1'b0}}, color} * {{lsbe_pkg::BYTE_W{1'b0}}, factor};
    assign scaled  = product[16 +: lsbe_pkg::BYTE_W];

    // slot k carries bit 7-k, msb first
    always_comb
    begin
        for (int k = 0; k < lsbe_pkg::NUM_SLOTS; k++)
        begin
            if (gap)
                slots[k] = '0;
            else if (scaled[lsbe_pkg::NUM_SLOTS-1-k])
                slots[k] = cfg.high_compare;
            else
                slots[k] = cfg.low_compare;
        end
    end

endmodule

// ===== hdl/led_strip_bit_encoder_unit.sv =====
// led_strip_bit_encoder_unit: pixel to led strip compare-slot encoder, top level
// an accepted pixel waits in the input holding register; its first beat then moves into the output register
// throughput: one result beat per cycle while out_ready is high; 3 beats per pixel, 3 + GAP_BYTES on a last pixel
// the single 8x17 scale multiplier in lsbe_encode is shared by the three bytes of a pixel
// reset: async active low, registers return to brightness 255, gamma off, compares 49/24
// depends on lsbe_pkg, lsbe_config, lsbe_encode
module led_strip_bit_encoder_unit #(
    parameter int unsigned GAP_BYTES = lsbe_pkg::GAP_BYTES_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // config write port
    input  logic                               cfg_write,
    input  logic [lsbe_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lsbe_pkg::BYTE_W-1:0]        cfg_data,
    // pixel input channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [lsbe_pkg::BYTE_W-1:0]        red,
    input  logic [lsbe_pkg::BYTE_W-1:0]        green,
    input  logic [lsbe_pkg::BYTE_W-1:0]        blue,
    input  logic                               last_pixel,
    // result output channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [lsbe_pkg::BYTE_W-1:0]        slot0,
    output logic [lsbe_pkg::BYTE_W-1:0]        slot1,
    output logic [lsbe_pkg::BYTE_W-1:0]        slot2,
    output logic [lsbe_pkg::BYTE_W-1:0]        slot3,
    output logic [lsbe_pkg::BYTE_W-1:0]        slot4,
    output logic [lsbe_pkg::BYTE_W-1:0]        slot5,
    output logic [lsbe_pkg::BYTE_W-1:0]        slot6,
    output logic [lsbe_pkg::BYTE_W-1:0]        slot7,
    output logic                               is_gap,
    output logic                               run_end
);

    // step counts the beats of one pixel: color bytes first, then the latch gap
    localparam int unsigned MAX_STEPS = lsbe_pkg::BYTES_PER_PIXEL + GAP_BYTES;
    localparam int unsigned STEP_W    = $clog2(MAX_STEPS);
    localparam logic [STEP_W-1:0] LAST_COLOR_STEP = STEP_W'(lsbe_pkg::BYTES_PER_PIXEL - 1);
    localparam logic [STEP_W-1:0] LAST_GAP_STEP   = STEP_W'(MAX_STEPS - 1);

    lsbe_pkg::cfg_t       cfg;
    lsbe_pkg::slot_row_t  slots;

    // input holding register
    logic                          hold_valid_reg, hold_valid_next;
    logic [lsbe_pkg::BYTE_W-1:0]   red_reg, green_reg, blue_reg;
    logic                          last_reg;
    logic [STEP_W-1:0]             step_reg, step_next;

    // output register
    logic                          out_valid_reg, out_valid_next;
    lsbe_pkg::slot_row_t           slots_reg;
    logic                          gap_reg;
    logic                          run_end_reg;

    logic                          advance;
    logic                          in_gap;
    logic                          final_beat;
    logic                          accept;

    lsbe_config u_config (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lsbe_encode u_encode (
        .cfg      (cfg),
        .red      (red_reg),
        .green    (green_reg),
        .blue     (blue_reg),
        .byte_sel (step_reg[1:0]),
        .gap      (in_gap),
        .slots    (slots)
    );

    // a beat moves into the output register whenever it is empty or being drained
    assign advance    = hold_valid_reg && (!out_valid_reg || out_ready);
    assign in_gap     = step_reg > LAST_COLOR_STEP;
    assign final_beat = last_reg ? (step_reg == LAST_GAP_STEP) : (step_reg == LAST_COLOR_STEP);

    // next pixel enters when the holding register is empty or while the current one hands off its final beat
    assign in_ready = !hold_valid_reg || (advance && final_beat);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        step_next       = step_reg;
        if (advance)
        begin
            if (final_beat)
            begin
                step_next       = '0;
                hold_valid_next = 1'b0;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
        if (accept)
            hold_valid_next = 1'b1;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            step_reg       <= step_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            red_reg   <= red;
            green_reg <= green;
            blue_reg  <= blue;
            last_reg  <= last_pixel;
        end
        if (advance)
        begin
            slots_reg   <= slots;
            gap_reg     <= in_gap;
            run_end_reg <= final_beat;
        end
    end

    assign out_valid = out_valid_reg;
    assign slot0     = slots_reg[0];
    assign slot1     = slots_reg[1];
    assign slot2     = slots_reg[2];
    assign slot3     = slots_reg[3];
    assign slot4     = slots_reg[4];
    assign slot5     = slots_reg[5];
    assign slot6     = slots_reg[6];
    assign slot7     = slots_reg[7];
    assign is_gap    = gap_reg;
    assign run_end   = run_end_reg;

endmodule
